/* rtl/core/arffn_pkg.sv */
`timescale 1ns / 1ps

package arffn_pkg;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_N       = 8'h4E;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;

  // One classified item: one or two result bytes, done applies to the last.
  typedef struct packed {
    logic       two;
    logic [7:0] c0;
    logic [7:0] c1;
    logic       done;
  } cmd_t;

endpackage

/* rtl/core/arff_data_line_normalizer.sv */
`timescale 1ns / 1ps
// Data-line normalizer: one line byte per item in, normalized bytes out.
// Input side: drive in_char with in_push; the byte is taken on a clock edge
// where in_push is high and in_full is low. A zero byte ends the line.
// Output side: while out_empty is low, out_char/out_run_last/out_line_done
// show the oldest result; it is taken on an edge with out_pop high.
// Each item gives zero, one or two results; out_run_last marks the last
// result of an item and out_line_done marks the line terminator.
// A result is written into the queue and then into the output stage register.
// Throughput: one item per cycle while in_full is low; the output stage sends
// one byte per cycle while out_pop is high, so two-byte items ('?', '%', escaped
// double quote) hold it for both bytes. A QUEUE_DEPTH-entry queue between the
// classifier and the output stage absorbs these and short output stalls; when it
// fills, in_full rises until out_pop drains it.
// Reset (rst_n low, synchronous) clears the quote, escape and comment state
// and empties the queue and the output stage.
module arff_data_line_normalizer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_char,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_line_done
);
  import arffn_pkg::*;

  cmd_t cmd, q_data;
  logic cmd_valid;
  logic accept;
  logic q_full, q_empty, q_pop;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  arffn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_char   (in_char),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  arffn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && cmd_valid),
    .wr_data (cmd),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  arffn_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char      (out_char),
    .out_run_last  (out_run_last),
    .out_line_done (out_line_done)
  );

endmodule

/* rtl/core/arffn_front.sv */
`timescale 1ns / 1ps

module arffn_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         in_char,
  output logic               cmd_valid,
  output arffn_pkg::cmd_t    cmd
);
  import arffn_pkg::*;

  logic inq_r, single_r, esc_r, skip_r;
  logic inq_nxt, single_nxt, esc_nxt, skip_nxt;
  logic [7:0] open_q;

  assign open_q = single_r ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    cmd_valid  = 1'b0;
    cmd        = '{two: 1'b0, c0: in_char, c1: CH_NUL, done: 1'b0};
    inq_nxt    = inq_r;
    single_nxt = single_r;
    esc_nxt    = esc_r;
    skip_nxt   = skip_r;
    if (skip_r) begin
      if (in_char == CH_NUL) begin
        inq_nxt    = 1'b0;
        single_nxt = 1'b0;
        esc_nxt    = 1'b0;
        skip_nxt   = 1'b0;
      end
    end else if (in_char == CH_NUL) begin
      cmd_valid  = 1'b1;
      cmd.c0     = CH_NUL;
      cmd.done   = 1'b1;
      inq_nxt    = 1'b0;
      single_nxt = 1'b0;
      esc_nxt    = 1'b0;
      skip_nxt   = 1'b0;
    end else if (inq_r) begin
      esc_nxt = 1'b0;
      if (esc_r && in_char == CH_LOWER_N) begin
        cmd_valid = 1'b1;
        cmd.c0    = CH_NL;
      end else if (esc_r && in_char == CH_SQUOTE && single_r) begin
        cmd_valid = 1'b1;
        cmd.c0    = CH_SQUOTE;
      end else if (esc_r && in_char == CH_DQUOTE) begin
        cmd_valid = 1'b1;
        cmd.two   = 1'b1;
        cmd.c0    = CH_BSLASH;
        cmd.c1    = CH_DQUOTE;
      end else if (in_char == open_q) begin
        cmd_valid  = 1'b1;
        cmd.c0     = CH_DQUOTE;
        inq_nxt    = 1'b0;
        single_nxt = 1'b0;
      end else if (in_char == CH_BSLASH) begin
        esc_nxt = 1'b1;
      end else begin
        cmd_valid = 1'b1;
      end
    end else if (in_char == CH_PCT) begin
      cmd_valid = 1'b1;
      cmd.two   = 1'b1;
      cmd.c0    = CH_NL;
      cmd.c1    = CH_NUL;
      cmd.done  = 1'b1;
      skip_nxt  = 1'b1;
    end else if (in_char == CH_SQUOTE || in_char == CH_DQUOTE) begin
      cmd_valid  = 1'b1;
      cmd.c0     = CH_DQUOTE;
      inq_nxt    = 1'b1;
      single_nxt = (in_char == CH_SQUOTE);
      esc_nxt    = 1'b0;
    end else if (in_char == CH_SPACE) begin
      cmd_valid = 1'b0;
    end else if (in_char == CH_QMARK) begin
      cmd_valid = 1'b1;
      cmd.two   = 1'b1;
      cmd.c0    = CH_N;
      cmd.c1    = CH_A;
    end else begin
      cmd_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_r    <= 1'b0;
      single_r <= 1'b0;
      esc_r    <= 1'b0;
      skip_r   <= 1'b0;
    end else if (accept) begin
      inq_r    <= inq_nxt;
      single_r <= single_nxt;
      esc_r    <= esc_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

/* rtl/core/arffn_queue.sv */
`timescale 1ns / 1ps

module arffn_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  arffn_pkg::cmd_t wr_data,
  input  logic            rd_en,
  output arffn_pkg::cmd_t rd_data,
  output logic            full,
  output logic            empty
);
  import arffn_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULLC = CW'(DEPTH);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == FULLC);
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/arffn_back.sv */
`timescale 1ns / 1ps

module arffn_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  arffn_pkg::cmd_t q_data,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_char,
  output logic            out_run_last,
  output logic            out_line_done
);
  import arffn_pkg::*;

  cmd_t cur_r;
  logic valid_r;
  logic phase_r;
  logic last_beat;
  logic take;

  assign last_beat     = !cur_r.two || phase_r;
  assign take          = out_pop && valid_r;
  assign q_pop         = !q_empty && (!valid_r || (take && last_beat));
  assign out_empty     = !valid_r;
  assign out_char      = phase_r ? cur_r.c1 : cur_r.c0;
  assign out_run_last  = last_beat;
  assign out_line_done = last_beat && cur_r.done;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (take) begin
      if (last_beat) begin
        valid_r <= 1'b0;
        phase_r <= 1'b0;
      end else begin
        phase_r <= 1'b1;
      end
    end
  end

endmodule
